// ----- src/dte_pkg.sv -----
// Shared constants, types and controller/datapath links for the decimal text emitter.
package dte_pkg;

   localparam int NUMBER_WIDTH        = 64;
   localparam int CHAR_WIDTH          = 8;
   localparam int DEFAULT_VALUE_WIDTH = 64;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = 8'h30;

   typedef enum logic [4:0] {
      ST_IDLE    = 5'b00001,
      ST_CONVERT = 5'b00010,
      ST_SKIP    = 5'b00100,
      ST_EMIT    = 5'b01000,
      ST_TERM    = 5'b10000
   } state_type;

   typedef struct packed {
      logic idle;
      logic load;
      logic shift;
      logic skip;
      logic put_digit;
      logic put_term;
   } cmd_type;

   typedef struct packed {
      logic conv_done;
      logic top_zero;
      logic digits_done;
      logic out_free;
   } status_type;

endpackage

// ----- src/dte_req_if.sv -----
// Input channel: number and terminator character with valid/ready.
interface dte_req_if import dte_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [NUMBER_WIDTH-1:0] number;
   logic [CHAR_WIDTH-1:0]   end_char;

   modport source (output valid, output number, output end_char, input ready);
   modport sink   (input valid, input number, input end_char, output ready);
endinterface

// ----- src/dte_rsp_if.sv -----
// Result channel: one character per transaction, last marks the terminator.
interface dte_rsp_if import dte_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;
   logic                  last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- src/dte_ctrl.sv -----
// Sequencer: load, shift-and-adjust, leading zero skip, digit emit, terminator.
module dte_ctrl import dte_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.idle = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.shift = 1'b1;
            if (status.conv_done) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, but always keep the units digit
            if (status.top_zero && !status.digits_done) begin
               cmd.skip = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.put_digit = 1'b1;
               if (status.digits_done) begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (status.out_free) begin
               cmd.put_term = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/dte_datapath.sv -----
// Binary shift register, BCD accumulator with add-3 adjust, counters, output register.
module dte_datapath import dte_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   input  logic [CHAR_WIDTH-1:0]   req_end_char,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [CHAR_WIDTH-1:0]   rsp_char_code,
   output logic                    rsp_last
);

   // decimal digits needed for 2**VALUE_WIDTH-1 (log10(2) ~ 0.30103)
   localparam int DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int BCD_W  = DIGITS * 4;
   localparam int BIT_CW = $clog2(VALUE_WIDTH);
   localparam int DIG_CW = $clog2(DIGITS);

   logic [VALUE_WIDTH-1:0] bin_ff,      bin_in;
   logic [BCD_W-1:0]       bcd_ff,      bcd_in;
   logic [BCD_W-1:0]       bcd_adj;
   logic [BIT_CW-1:0]      bit_cnt_ff,  bit_cnt_in;
   logic [DIG_CW-1:0]      dig_cnt_ff,  dig_cnt_in;
   logic [CHAR_WIDTH-1:0]  end_char_ff, end_char_in;
   logic [CHAR_WIDTH-1:0]  out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;
   logic                   out_valid_ff, out_valid_in;
   logic [3:0]             top_digit;

   assign top_digit = bcd_ff[BCD_W-1 -: 4];

   // every digit of 5 or more gets +3 before the doubling shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                        : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in       = bin_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      end_char_in  = end_char_ff;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_ready;

      if (cmd.load) begin
         bin_in      = req_number[VALUE_WIDTH-1:0];
         bcd_in      = '0;
         bit_cnt_in  = BIT_CW'(VALUE_WIDTH - 1);
         dig_cnt_in  = DIG_CW'(DIGITS - 1);
         end_char_in = req_end_char;
      end
      if (cmd.shift) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_WIDTH-1]};
         bin_in     = {bin_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end
      if (cmd.skip || cmd.put_digit) begin
         bcd_in     = {bcd_ff[BCD_W-5:0], 4'b0000};
         dig_cnt_in = dig_cnt_ff - 1'b1;
      end
      if (cmd.put_digit) begin
         out_char_in  = ASCII_ZERO + {4'b0000, top_digit};
         out_last_in  = 1'b0;
         out_valid_in = 1'b1;
      end
      if (cmd.put_term) begin
         out_char_in  = end_char_ff;
         out_last_in  = 1'b1;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      bin_ff      <= bin_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      end_char_ff <= end_char_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign status.conv_done   = (bit_cnt_ff == '0);
   assign status.top_zero    = (top_digit == 4'd0);
   assign status.digits_done = (dig_cnt_ff == '0);
   assign status.out_free    = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_char_code = out_char_ff;
   assign rsp_last      = out_last_ff;

endmodule

// ----- src/decimal_text_emitter_unit.sv -----
// Decimal text emitter: converts an unsigned number to ASCII decimal digits, MSD first,
// no leading zeros (zero gives a single '0'), followed by the terminator character with
// last set. Only the low VALUE_WIDTH bits of number are used. One number is converted at
// a time: the accept, the one-bit-per-cycle shift-and-add-3 loop over VALUE_WIDTH bits,
// the dropping of leading zero digits one at a time, then the digits and the terminator,
// each put out as the result side takes it. The output register lets the next number be
// accepted while the terminator waits.
module decimal_text_emitter_unit import dte_pkg::*; #(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  logic      clock,
   input  logic      reset,
   dte_req_if.sink   req_ch,
   dte_rsp_if.source rsp_ch
);

   cmd_type    cmd;
   status_type status;

   assign req_ch.ready = cmd.idle;

   dte_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   dte_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_number    (req_ch.number),
      .req_end_char  (req_ch.end_char),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_char_code (rsp_ch.char_code),
      .rsp_last      (rsp_ch.last)
   );

   // one number at a time: after a transaction the input side closes
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input accepted twice in a row");

   // every non-final character is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.last |->
         (rsp_ch.char_code >= ASCII_ZERO) && (rsp_ch.char_code <= ASCII_ZERO + 8'd9))
      else $error("digit result out of range");

   // a fresh number is never taken while digits of the previous one are pending
   a_no_accept_mid_run: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !(rsp_ch.valid && !rsp_ch.last))
      else $error("input accepted while a digit is still pending");

endmodule

// ----- dv/decimal_text_emitter_unit_test.sv -----
// Testbench for decimal_text_emitter_unit: predicts the ASCII text of each number and checks it.
module decimal_text_emitter_unit_test import dte_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CLOCK_HALF_NS    = 6;
   localparam int  TEXT_VALUE_WIDTH = DEFAULT_VALUE_WIDTH;
   localparam int  DECIMAL_BASE     = 10;
   localparam int  RANDOM_NUMBERS   = 60;
   localparam int  TAIL_NUMBERS     = 20;
   localparam int  LONG_HOLD_CYCLES = 400;
   localparam int  SETTLE_CYCLES    = 120;
   localparam time TIMEOUT_NS       = 5_000_000;

   localparam logic [CHAR_WIDTH-1:0] CHAR_NUL      = 8'h00;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NEWLINE  = 8'h0A;
   localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE    = 8'h20;
   localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA    = 8'h2C;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ALL_ONES = 8'hFF;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] char_code;
      logic                  last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dte_req_if req_ch ();
   dte_rsp_if rsp_ch ();

   decimal_text_emitter_unit #(
      .VALUE_WIDTH (TEXT_VALUE_WIDTH)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLOCK_HALF_NS) clock = ~clock;

   text_char_type expected_chars[$];
   text_char_type expected_char;
   int            error_count       = 0;
   bit            sender_gaps_on    = 1'b0;
   bit            receiver_stall_on = 1'b0;
   int            receiver_hold_req = 0;

   // Decimal text of one number: digits MSD first, then the terminator marked last.
   function automatic void predict_text(input logic [NUMBER_WIDTH-1:0] number,
                                        input logic [CHAR_WIDTH-1:0]   end_char);
      logic [NUMBER_WIDTH-1:0] rest;
      logic [CHAR_WIDTH-1:0]   digits[$];
      rest = number & ({NUMBER_WIDTH{1'b1}} >> (NUMBER_WIDTH - TEXT_VALUE_WIDTH));
      do begin
         digits.push_front(ASCII_ZERO + CHAR_WIDTH'(rest % DECIMAL_BASE));
         rest = rest / DECIMAL_BASE;
      end while (rest != '0);
      foreach (digits[i])
         expected_chars.push_back('{char_code: digits[i], last: 1'b0});
      expected_chars.push_back('{char_code: end_char, last: 1'b1});
   endfunction

   // Valid is left high after acceptance; it only drops when the sender goes idle.
   task automatic send_number(input logic [NUMBER_WIDTH-1:0] number,
                              input logic [CHAR_WIDTH-1:0]   end_char);
      if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.number   <= number;
      req_ch.end_char <= end_char;
      do @(posedge clock); while (!req_ch.ready);
      predict_text(number, end_char);
   endtask

   task automatic wait_text_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   // Mix of magnitudes so every digit count from 1 to 20 shows up.
   function automatic logic [NUMBER_WIDTH-1:0] random_number();
      logic [NUMBER_WIDTH-1:0] wide;
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 3))
         0:       return NUMBER_WIDTH'($urandom_range(0, 999));
         1:       return wide;
         default: return wide >> $urandom_range(0, NUMBER_WIDTH - 1);
      endcase
   endfunction

   task automatic test_directed_values();
      send_number(64'd0, CHAR_NEWLINE);
      send_number(64'd1, CHAR_NEWLINE);
      send_number(64'd9, CHAR_SPACE);
      send_number(64'd10, CHAR_SPACE);
      send_number(64'd99, CHAR_COMMA);
      send_number(64'd100, CHAR_COMMA);
      send_number(64'd1000000000, CHAR_NEWLINE);
      send_number(64'd9999999999999999999, CHAR_NEWLINE);
      send_number(64'd10000000000000000000, CHAR_NEWLINE);
      send_number(64'h8000_0000_0000_0000, CHAR_SPACE);
      send_number(64'h7FFF_FFFF_FFFF_FFFF, CHAR_SPACE);
      send_number({NUMBER_WIDTH{1'b1}}, CHAR_NEWLINE);
      wait_text_drained();
   endtask

   // Terminator codes at the extremes and equal to digit codes.
   task automatic test_terminator_codes();
      send_number(64'd0, CHAR_NUL);
      send_number({NUMBER_WIDTH{1'b1}}, CHAR_ALL_ONES);
      send_number(64'd5, ASCII_ZERO + 8'd5);
      send_number(64'd123, ASCII_ZERO);
      send_number(64'd0, ASCII_ZERO);
      send_number(64'd987654321, ASCII_ZERO + 8'd9);
      send_number(64'd42, 8'h55);
      send_number(64'd42, 8'hAA);
      wait_text_drained();
   endtask

   task automatic test_random_numbers();
      sender_gaps_on    = 1'b1;
      receiver_stall_on = 1'b1;
      for (int i = 0; i < RANDOM_NUMBERS; i++) begin
         send_number(random_number(), CHAR_WIDTH'($urandom));
         if (i == RANDOM_NUMBERS / 2) wait_text_drained();
      end
      wait_text_drained();
   endtask

   // Result side blocked for a long stretch while numbers keep coming.
   task automatic test_output_backpressure();
      sender_gaps_on    = 1'b0;
      receiver_hold_req = LONG_HOLD_CYCLES;
      for (int i = 0; i < 5; i++)
         send_number({$urandom, $urandom}, CHAR_WIDTH'($urandom));
      wait_text_drained();
   endtask

   task automatic test_back_to_back();
      sender_gaps_on    = 1'b0;
      receiver_stall_on = 1'b0;
      for (int i = 0; i < TAIL_NUMBERS; i++)
         send_number(random_number(), CHAR_WIDTH'($urandom));
   endtask

   initial begin : rsp_ready_driver
      int hold;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (receiver_hold_req != 0) begin
            hold              = receiver_hold_req;
            receiver_hold_req = 0;
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (receiver_stall_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected transaction: char_code=%h last=%b",
                   rsp_ch.char_code, rsp_ch.last);
            error_count++;
         end else begin
            expected_char = expected_chars.pop_front();
            if (rsp_ch.char_code !== expected_char.char_code) begin
               $error("char_code: expected %h, actual %h",
                      expected_char.char_code, rsp_ch.char_code);
               error_count++;
            end
            if (rsp_ch.last !== expected_char.last) begin
               $error("last: expected %b, actual %b", expected_char.last, rsp_ch.last);
               error_count++;
            end
         end
      end
   end

   initial begin
      req_ch.valid    = 1'b0;
      req_ch.number   = '0;
      req_ch.end_char = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_values();
      test_terminator_codes();
      test_random_numbers();
      test_output_backpressure();
      test_back_to_back();

      wait_text_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
